// ===== rtl/lz77_stream_decompressor_macros.svh =====
// assertion macros shared by the decompressor rtl
// no dependencies; taken in by files that carry assertions
`ifndef LZ77_STREAM_DECOMPRESSOR_MACROS_SVH
`define LZ77_STREAM_DECOMPRESSOR_MACROS_SVH

// same-cycle implication under the async reset
`define LZD_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("lzd assertion failed");

// next-cycle implication under the async reset
`define LZD_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("lzd assertion failed");

`endif

// ===== rtl/lzd_pkg.sv =====
// shared types and constants of the lzss stream decompressor
// no dependencies
package lzd_pkg;

	localparam int WIN_DEPTH  = 4096;
	localparam int WIN_AW     = $clog2(WIN_DEPTH);
	localparam int MAX_RUN    = 18;
	localparam int LEN_W      = $clog2(MAX_RUN + 1);
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int APB_AW     = 3;

	// register word index taken from paddr[2]
	localparam logic REG_IDX_FLAG_ORDER = 1'b0;

	// flag bit order codes
	localparam logic ORDER_MSB_FIRST = 1'b0;
	localparam logic ORDER_LSB_FIRST = 1'b1;

	typedef enum logic [1:0] {
		CMD_LIT,
		CMD_COPY,
		CMD_END
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [7:0]         lit;
		logic [WIN_AW-1:0]  offset;
		logic [LEN_W-1:0]   len;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_DATA
	} back_state_t;

endpackage

// ===== rtl/lzd_ram.sv =====
// generic simple dual-port ram with registered read
// no dependencies
module lzd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/lzd_fifo.sv =====
// short command queue between the token front and the window back
// depends on lzd_pkg
module lzd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lzd_pkg::cmd_t cmd_in,
	output logic          full,
	input  logic          pop,
	output lzd_pkg::cmd_t cmd_out,
	output logic          empty
);

	lzd_pkg::cmd_t                entry_q [lzd_pkg::FIFO_DEPTH];
	logic [lzd_pkg::FIFO_AW-1:0]  wr_ptr_q;
	logic [lzd_pkg::FIFO_AW-1:0]  rd_ptr_q;
	logic [lzd_pkg::FIFO_AW:0]    count_q;

	assign full    = (count_q == (lzd_pkg::FIFO_AW+1)'(lzd_pkg::FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign cmd_out = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/lzd_front.sv =====
// token front: takes compressed bytes, tracks flag bits and pair phase,
// and queues literal, copy and end commands; depends on lzd_pkg
module lzd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          flag_order,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,   // [7:0] in_byte
	input  logic          s_tuser,   // [0] stream_start
	input  logic          init_done,
	input  logic          fifo_full,
	output logic          push,
	output lzd_pkg::cmd_t cmd
);

	logic [7:0] flag_shift_q;
	logic [3:0] bits_left_q;
	logic       pair_phase_q;
	logic [7:0] pair_first_q;
	logic       finished_q;

	logic       accept;
	logic [3:0] bits_left;
	logic       pair_phase;
	logic       finished;
	logic       flag_bit;
	logic [lzd_pkg::WIN_AW-1:0] offset;

	assign s_tready = init_done && !fifo_full;
	assign accept   = s_tvalid && s_tready;

	// stream start clears phase before the byte is decoded
	assign bits_left  = s_tuser ? 4'd0 : bits_left_q;
	assign pair_phase = s_tuser ? 1'b0 : pair_phase_q;
	assign finished   = s_tuser ? 1'b0 : finished_q;
	assign flag_bit   = (flag_order == lzd_pkg::ORDER_LSB_FIRST) ? flag_shift_q[0]
		: flag_shift_q[7];
	assign offset     = {pair_first_q[7:4], s_tdata};

	always_comb begin
		push       = 1'b0;
		cmd.kind   = lzd_pkg::CMD_LIT;
		cmd.lit    = s_tdata;
		cmd.offset = offset;
		cmd.len    = lzd_pkg::LEN_W'(lzd_pkg::MAX_RUN) - {1'b0, pair_first_q[3:0]};
		if (accept && !finished) begin
			if (pair_phase) begin
				push     = 1'b1;
				cmd.kind = (offset == '0) ? lzd_pkg::CMD_END : lzd_pkg::CMD_COPY;
			end else if (bits_left != 4'd0 && flag_bit) begin
				push = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_shift_q <= '0;
			bits_left_q  <= '0;
			pair_phase_q <= 1'b0;
			pair_first_q <= '0;
			finished_q   <= 1'b0;
		end else if (accept) begin
			bits_left_q  <= bits_left;
			pair_phase_q <= pair_phase;
			finished_q   <= finished;
			if (!finished) begin
				if (pair_phase) begin
					pair_phase_q <= 1'b0;
					finished_q   <= (offset == '0);
				end else if (bits_left == 4'd0) begin
					flag_shift_q <= s_tdata;
					bits_left_q  <= 4'd8;
				end else begin
					bits_left_q <= bits_left - 1'b1;
					if (flag_order == lzd_pkg::ORDER_LSB_FIRST) begin
						flag_shift_q <= {1'b0, flag_shift_q[7:1]};
					end else begin
						flag_shift_q <= {flag_shift_q[6:0], 1'b0};
					end
					if (!flag_bit) begin
						pair_first_q <= s_tdata;
						pair_phase_q <= 1'b1;
					end
				end
			end
		end
	end

endmodule

// ===== rtl/lzd_back.sv =====
// window back: clears the history window, runs literal, copy and end
// commands and holds the output register; depends on lzd_pkg, lzd_ram
`include "lz77_stream_decompressor_macros.svh"

module lzd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fifo_empty,
	input  lzd_pkg::cmd_t cmd,
	output logic          pop,
	output logic          init_done,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,   // [7:0] out_byte
	output logic          m_tlast,   // run_last
	output logic          m_tuser    // [0] stream_end
);

	lzd_pkg::back_state_t state_q, state_d;

	logic [lzd_pkg::WIN_AW-1:0] wp_q, wp_d;
	logic [lzd_pkg::WIN_AW-1:0] off_q, off_d;
	logic [lzd_pkg::LEN_W-1:0]  len_q, len_d;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       out_end_q;

	logic       load;
	logic [7:0] load_byte;
	logic       load_last;
	logic       load_end;
	logic       slot_free;

	logic                       ram_we;
	logic [lzd_pkg::WIN_AW-1:0] ram_waddr;
	logic [7:0]                 ram_wdata;
	logic                       ram_re;
	logic [lzd_pkg::WIN_AW-1:0] ram_raddr;
	logic [7:0]                 ram_rdata;

	lzd_ram #(
		.WIDTH(8),
		.DEPTH(lzd_pkg::WIN_DEPTH)
	) u_window (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign slot_free = !out_valid_q || m_tready;
	assign init_done = (state_q != lzd_pkg::ST_CLEAR);

	always_comb begin
		state_d   = state_q;
		wp_d      = wp_q;
		off_d     = off_q;
		len_d     = len_q;
		pop       = 1'b0;
		load      = 1'b0;
		load_byte = '0;
		load_last = 1'b0;
		load_end  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = wp_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = wp_q - off_q;
		unique case (state_q)
			lzd_pkg::ST_CLEAR: begin
				// sweep zeros; pointer wraps back to zero at the end
				ram_we = 1'b1;
				wp_d   = wp_q + 1'b1;
				if (wp_q == lzd_pkg::WIN_AW'(lzd_pkg::WIN_DEPTH - 1)) begin
					state_d = lzd_pkg::ST_IDLE;
				end
			end
			lzd_pkg::ST_IDLE: begin
				if (!fifo_empty && slot_free) begin
					pop = 1'b1;
					unique case (cmd.kind)
						lzd_pkg::CMD_LIT: begin
							ram_we    = 1'b1;
							ram_wdata = cmd.lit;
							wp_d      = wp_q + 1'b1;
							load      = 1'b1;
							load_byte = cmd.lit;
							load_last = 1'b1;
						end
						lzd_pkg::CMD_END: begin
							load      = 1'b1;
							load_last = 1'b1;
							load_end  = 1'b1;
						end
						lzd_pkg::CMD_COPY: begin
							ram_re    = 1'b1;
							ram_raddr = wp_q - cmd.offset;
							off_d     = cmd.offset;
							len_d     = cmd.len;
							state_d   = lzd_pkg::ST_DATA;
						end
						default: begin
							pop = 1'b1;
						end
					endcase
				end
			end
			lzd_pkg::ST_READ: begin
				ram_re  = 1'b1;
				state_d = lzd_pkg::ST_DATA;
			end
			lzd_pkg::ST_DATA: begin
				// read data holds until the output slot frees
				if (slot_free) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata;
					wp_d      = wp_q + 1'b1;
					len_d     = len_q - 1'b1;
					load      = 1'b1;
					load_byte = ram_rdata;
					load_last = (len_q == lzd_pkg::LEN_W'(1));
					state_d   = load_last ? lzd_pkg::ST_IDLE : lzd_pkg::ST_READ;
				end
			end
			default: begin
				state_d = lzd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lzd_pkg::ST_CLEAR;
			wp_q        <= '0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			wp_q    <= wp_d;
			len_q   <= len_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		off_q <= off_d;
		if (load) begin
			out_byte_q <= load_byte;
			out_last_q <= load_last;
			out_end_q  <= load_end;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_end_q;

	`LZD_ASSERT_IMP(a_no_rw_same_cycle, clk, arst_n, ram_we, !ram_re)
	`LZD_ASSERT_IMP(a_load_needs_slot, clk, arst_n, load, slot_free)
	`LZD_ASSERT_IMP(a_no_pop_in_clear, clk, arst_n, state_q == lzd_pkg::ST_CLEAR, !pop)
	`LZD_ASSERT_IMP(a_copy_len_live, clk, arst_n,
		state_q == lzd_pkg::ST_READ || state_q == lzd_pkg::ST_DATA, len_q != '0)
	`LZD_ASSERT_NXT(a_read_then_data, clk, arst_n, state_q == lzd_pkg::ST_READ,
		state_q == lzd_pkg::ST_DATA)

endmodule

// ===== rtl/lz77_stream_decompressor.sv =====
// top level of the lzss stream decompressor: apb register, token front,
// command queue and window back; depends on lzd_pkg, lzd_front, lzd_fifo, lzd_back
//
//   port group   dir   item
//   s_*          in    one compressed byte, stream start in tuser
//   m_*          out   one decoded byte, last-of-item in tlast, end marker in tuser
//   apb          in    flag bit order register at byte address 0
//
// after reset the window is swept to zero with s_tready low;
// apb writes are taken during the sweep
// flag, pair-first and ignored bytes produce no command
// a literal or end token is registered in the queue, then in the output register of the back
// in the back a copy does one window read, then one write and output, per byte
// through the single-ported use of the window ram
// a four-entry queue lets the front keep taking bytes while a copy runs
module lz77_stream_decompressor (
	input  logic                        clk,
	input  logic                        arst_n,
	// input stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] in_byte
	input  logic                        s_tuser,   // [0] stream_start
	// output stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [7:0]                  m_tdata,   // [7:0] out_byte
	output logic                        m_tlast,   // run_last
	output logic                        m_tuser,   // [0] stream_end
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lzd_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	logic          flag_order_q;
	logic          cfg_wr;

	logic          init_done;
	logic          fifo_full;
	logic          fifo_empty;
	logic          push;
	logic          pop;
	lzd_pkg::cmd_t cmd_front;
	lzd_pkg::cmd_t cmd_back;

	// apb: zero wait states, word index in paddr[2]
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == lzd_pkg::REG_IDX_FLAG_ORDER) ? {31'b0, flag_order_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_order_q <= lzd_pkg::ORDER_MSB_FIRST;
		end else if (cfg_wr && paddr[2] == lzd_pkg::REG_IDX_FLAG_ORDER) begin
			flag_order_q <= pwdata[0];
		end
	end

	// front decodes flags and pairs into commands
	lzd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.flag_order(flag_order_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.init_done (init_done),
		.fifo_full (fifo_full),
		.push      (push),
		.cmd       (cmd_front)
	);

	// decouples byte intake from long copies
	lzd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.cmd_in (cmd_front),
		.full   (fifo_full),
		.pop    (pop),
		.cmd_out(cmd_back),
		.empty  (fifo_empty)
	);

	// back owns the history window and the output register
	lzd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fifo_empty(fifo_empty),
		.cmd       (cmd_back),
		.pop       (pop),
		.init_done (init_done),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule
